// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre |-> post in the same cycle
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// pre |=> post in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/sch_pkg.sv =====
// ----------------------------------------------------------------------------
// sch_pkg
// Shared types for the sphere versus capsule hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package sch_pkg;

	// closest point on the capsule axis
	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_END      = 2'd1,
		REGION_START    = 2'd2
	} region_t;

endpackage

`default_nettype wire

// ===== design/sphere_capsule_hit_test.sv =====
// ----------------------------------------------------------------------------
// sphere_capsule_hit_test
// Exact sphere versus capsule hit test on signed Q12.4 coordinates.
// Query channel: sphere centre and radius, capsule start, end and radius, one
// transaction per query_valid & query_ready. Result channel: hit and region,
// one transaction per result_valid & result_ready, in query order.
// An accepted query passes the seven register stages (differences,
// products, sums, region decision, partial products, product sums, final
// compare) in order into the result register. Throughput: one query per
// cycle while the receiver does not stall.
// Each stage holds its item while the stage after it is full and stalled, so a
// stalled receiver fills the pipeline; query_ready falls only when every stage
// holds an item. Empty stages ahead of a stall keep taking queries.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_capsule_hit_test #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         query_valid,
	output      logic                         query_ready,
	input  wire logic signed [COORD_BITS-1:0] sphere_x,
	input  wire logic signed [COORD_BITS-1:0] sphere_y,
	input  wire logic signed [COORD_BITS-1:0] sphere_z,
	input  wire logic        [COORD_BITS-2:0] sphere_radius,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] start_z,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic signed [COORD_BITS-1:0] end_z,
	input  wire logic        [COORD_BITS-2:0] capsule_radius,

	output      logic                         result_valid,
	input  wire logic                         result_ready,
	output      logic                         hit,
	output      logic [1:0]                   region
);

`include "assert_macros.svh"

	localparam int CW = COORD_BITS;     // coordinate width
	localparam int LW = 2 * CW + 2;     // squared lengths
	localparam int DW = 2 * CW + 3;     // signed dot product
	localparam int HW = LW / 2;         // half operand for partial products
	localparam int PW = 2 * LW;         // full products

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_out;

	logic result_valid_q;
	logic hit_q;
	sch_pkg::region_t region_q;

	assign en_out = !result_valid_q || result_ready;
	assign en_s6  = !v_s6 || en_out;
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign query_ready  = en_s1;
	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign region       = region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			v_s6           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= query_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_out) result_valid_q <= v_s6;
		end
	end

	// stage 1: axis differences and radius sum
	logic signed [CW-1:0] s_c [3];
	logic signed [CW-1:0] a_c [3];
	logic signed [CW-1:0] b_c [3];

	assign s_c[0] = sphere_x;
	assign s_c[1] = sphere_y;
	assign s_c[2] = sphere_z;
	assign a_c[0] = start_x;
	assign a_c[1] = start_y;
	assign a_c[2] = start_z;
	assign b_c[0] = end_x;
	assign b_c[1] = end_y;
	assign b_c[2] = end_z;

	logic signed [CW:0] d_s1 [3];
	logic signed [CW:0] w_s1 [3];
	logic signed [CW:0] e_s1 [3];
	logic [CW-1:0] rsum_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= $signed({b_c[k][CW-1], b_c[k]}) - $signed({a_c[k][CW-1], a_c[k]});
				w_s1[k] <= $signed({s_c[k][CW-1], s_c[k]}) - $signed({a_c[k][CW-1], a_c[k]});
				e_s1[k] <= $signed({s_c[k][CW-1], s_c[k]}) - $signed({b_c[k][CW-1], b_c[k]});
			end
			rsum_s1 <= CW'(sphere_radius) + CW'(capsule_radius);
		end
	end

	// stage 2: per-axis products
	logic signed [2*CW+1:0] dd_c [3];
	logic signed [2*CW+1:0] ww_c [3];
	logic signed [2*CW+1:0] ee_c [3];
	logic signed [2*CW+1:0] dw_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dd_c[k] = d_s1[k] * d_s1[k];
			ww_c[k] = w_s1[k] * w_s1[k];
			ee_c[k] = e_s1[k] * e_s1[k];
			dw_c[k] = d_s1[k] * w_s1[k];
		end
	end

	logic        [2*CW-1:0] dsq_s2 [3];
	logic        [2*CW-1:0] wsq_s2 [3];
	logic        [2*CW-1:0] esq_s2 [3];
	logic signed [2*CW:0]   dw_s2  [3];
	logic        [2*CW-1:0] rr_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int k = 0; k < 3; k++) begin
				dsq_s2[k] <= dd_c[k][2*CW-1:0];
				wsq_s2[k] <= ww_c[k][2*CW-1:0];
				esq_s2[k] <= ee_c[k][2*CW-1:0];
				dw_s2[k]  <= dw_c[k][2*CW:0];
			end
			rr_s2 <= rsum_s1 * rsum_s1;
		end
	end

	// stage 3: sums over the axes
	logic        [LW-1:0]   l_s3;
	logic        [LW-1:0]   wsq_s3;
	logic        [LW-1:0]   esq_s3;
	logic signed [DW-1:0]   dot_s3;
	logic        [2*CW-1:0] rr_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			l_s3   <= LW'(dsq_s2[0]) + LW'(dsq_s2[1]) + LW'(dsq_s2[2]);
			wsq_s3 <= LW'(wsq_s2[0]) + LW'(wsq_s2[1]) + LW'(wsq_s2[2]);
			esq_s3 <= LW'(esq_s2[0]) + LW'(esq_s2[1]) + LW'(esq_s2[2]);
			dot_s3 <= DW'(dw_s2[0]) + DW'(dw_s2[1]) + DW'(dw_s2[2]);
			rr_s3  <= rr_s2;
		end
	end

	// stage 4: region decision, end point tests, interior operands
	logic             zero_len_c;
	logic             dot_pos_c;
	logic [LW-1:0]    dot_u_c;
	logic [LW-1:0]    rr_ext_c;
	sch_pkg::region_t region_c;

	assign zero_len_c = (l_s3 == '0);
	assign dot_pos_c  = !dot_s3[DW-1] && (dot_s3 != '0);
	assign dot_u_c    = dot_s3[LW-1:0];
	assign rr_ext_c   = LW'(rr_s3);

	always_comb begin
		if (zero_len_c || !dot_pos_c) begin
			region_c = sch_pkg::REGION_START;
		end else if (dot_u_c <= l_s3) begin
			region_c = sch_pkg::REGION_INTERIOR;
		end else begin
			region_c = sch_pkg::REGION_END;
		end
	end

	sch_pkg::region_t region_s4;
	logic             hit_start_s4;
	logic             hit_end_s4;
	logic [LW-1:0]    l_s4;
	logic [LW-1:0]    m_s4;
	logic [LW-1:0]    t_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			region_s4    <= region_c;
			hit_start_s4 <= wsq_s3 < rr_ext_c;
			hit_end_s4   <= esq_s3 < rr_ext_c;
			l_s4         <= l_s3;
			m_s4         <= (wsq_s3 > rr_ext_c) ? (wsq_s3 - rr_ext_c) : '0;
			t_s4         <= dot_u_c;
		end
	end

	// stage 5: partial products of L * (wsq - rr) and t * t
	sch_pkg::region_t region_s5;
	logic             hit_start_s5;
	logic             hit_end_s5;
	logic [LW-1:0]    lm_ll_s5, lm_lh_s5, lm_hl_s5, lm_hh_s5;
	logic [LW-1:0]    tt_ll_s5, tt_lh_s5, tt_hh_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			region_s5    <= region_s4;
			hit_start_s5 <= hit_start_s4;
			hit_end_s5   <= hit_end_s4;
			lm_ll_s5     <= l_s4[HW-1:0]  * m_s4[HW-1:0];
			lm_lh_s5     <= l_s4[HW-1:0]  * m_s4[LW-1:HW];
			lm_hl_s5     <= l_s4[LW-1:HW] * m_s4[HW-1:0];
			lm_hh_s5     <= l_s4[LW-1:HW] * m_s4[LW-1:HW];
			tt_ll_s5     <= t_s4[HW-1:0]  * t_s4[HW-1:0];
			tt_lh_s5     <= t_s4[HW-1:0]  * t_s4[LW-1:HW];
			tt_hh_s5     <= t_s4[LW-1:HW] * t_s4[LW-1:HW];
		end
	end

	// stage 6: full products
	sch_pkg::region_t region_s6;
	logic             hit_start_s6;
	logic             hit_end_s6;
	logic [PW-1:0]    lm_s6;
	logic [PW-1:0]    tt_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			region_s6    <= region_s5;
			hit_start_s6 <= hit_start_s5;
			hit_end_s6   <= hit_end_s5;
			lm_s6        <= PW'(lm_ll_s5)
				+ ((PW'(lm_lh_s5) + PW'(lm_hl_s5)) << HW)
				+ (PW'(lm_hh_s5) << LW);
			tt_s6        <= PW'(tt_ll_s5)
				+ (PW'(tt_lh_s5) << (HW + 1))
				+ (PW'(tt_hh_s5) << LW);
		end
	end

	// output register: interior compare and final select
	always_ff @(posedge clk) begin
		if (en_out) begin
			region_q <= region_s6;
			case (region_s6)
				sch_pkg::REGION_INTERIOR: hit_q <= tt_s6 > lm_s6;
				sch_pkg::REGION_END:      hit_q <= hit_end_s6;
				default:                  hit_q <= hit_start_s6;
			endcase
		end
	end

	// checks
	`ASSERT_IMPLY(a_zero_len_start, v_s4 && (l_s4 == '0), region_s4 == sch_pkg::REGION_START, "zero-length capsule not at start")
	`ASSERT_IMPLY(a_full_stall, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && result_valid_q && !result_ready, !query_ready, "query taken while pipeline full and stalled")
	`ASSERT_NEXT(a_accept_fill, query_valid && query_ready, v_s1, "accepted transaction missing from first stage")
	`ASSERT_NEXT(a_drain_out, v_s6 && en_out, result_valid_q, "last stage item not moved to output")

endmodule

`default_nettype wire

// ===== bench/sphere_capsule_hit_test_test.sv =====
// ----------------------------------------------------------------------------
// sphere_capsule_hit_test_test
// Self-checking bench for the sphere versus capsule hit test. Queries are
// sent one transaction at a time. Each accepted query is predicted with exact
// wide integer arithmetic, and each result is compared in order against the
// oldest prediction. Directed corners, region boundaries, touching cases and
// zero-length capsules first, then random traffic under idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sphere_capsule_hit_test_test;

	localparam int CB           = 16;
	localparam int PIPE_LATENCY = 7;
	localparam int RAND_PER_MIX = 100;

	typedef struct packed {
		logic signed [CB-1:0] sphere_x;
		logic signed [CB-1:0] sphere_y;
		logic signed [CB-1:0] sphere_z;
		logic        [CB-2:0] sphere_radius;
		logic signed [CB-1:0] start_x;
		logic signed [CB-1:0] start_y;
		logic signed [CB-1:0] start_z;
		logic signed [CB-1:0] end_x;
		logic signed [CB-1:0] end_y;
		logic signed [CB-1:0] end_z;
		logic        [CB-2:0] capsule_radius;
	} query_t;

	localparam int QW = $bits(query_t);

	typedef struct packed {
		logic             hit;
		sch_pkg::region_t region;
	} hit_region_t;

	logic        clk;
	logic        arst_n;
	logic        query_valid;
	logic        query_ready;
	query_t      query;
	logic        result_valid;
	logic        result_ready;
	logic        hit;
	logic [1:0]  region;

	hit_region_t expected_hits[$];
	hit_region_t oldest;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          error_count;
	int          query_count;
	int          hit_count;
	int          region_count[3];

	sphere_capsule_hit_test #(
		.COORD_BITS(CB)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.query_valid   (query_valid),
		.query_ready   (query_ready),
		.sphere_x      (query.sphere_x),
		.sphere_y      (query.sphere_y),
		.sphere_z      (query.sphere_z),
		.sphere_radius (query.sphere_radius),
		.start_x       (query.start_x),
		.start_y       (query.start_y),
		.start_z       (query.start_z),
		.end_x         (query.end_x),
		.end_y         (query.end_y),
		.end_z         (query.end_z),
		.capsule_radius(query.capsule_radius),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.hit           (hit),
		.region        (region)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#(20 * 200000);
		$display("timeout: results still outstanding: %0d", expected_hits.size());
		$display("== FAIL ==");
		$finish;
	end

	// exact closest-point test, no division
	function automatic hit_region_t predict_hit_region(query_t q);
		longint      s[3], a[3], b[3];
		longint      d, w, e;
		longint      len_sq, w_sq, e_sq, dot, rsum, r_sq;
		logic [127:0] lhs, rhs, term;
		hit_region_t r;
		s[0] = longint'($signed(q.sphere_x));
		s[1] = longint'($signed(q.sphere_y));
		s[2] = longint'($signed(q.sphere_z));
		a[0] = longint'($signed(q.start_x));
		a[1] = longint'($signed(q.start_y));
		a[2] = longint'($signed(q.start_z));
		b[0] = longint'($signed(q.end_x));
		b[1] = longint'($signed(q.end_y));
		b[2] = longint'($signed(q.end_z));
		rsum = longint'(q.sphere_radius) + longint'(q.capsule_radius);
		r_sq = rsum * rsum;
		len_sq = 0;
		w_sq = 0;
		e_sq = 0;
		dot = 0;
		for (int k = 0; k < 3; k++) begin
			d = b[k] - a[k];
			w = s[k] - a[k];
			e = s[k] - b[k];
			len_sq += d * d;
			w_sq += w * w;
			e_sq += e * e;
			dot += d * w;
		end
		if (len_sq == 0 || dot <= 0) begin
			r.region = sch_pkg::REGION_START;
			r.hit = (w_sq < r_sq);
		end else if (dot <= len_sq) begin
			r.region = sch_pkg::REGION_INTERIOR;
			lhs = 128'(w_sq);
			lhs = lhs * len_sq;
			rhs = 128'(dot);
			rhs = rhs * dot;
			term = 128'(r_sq);
			term = term * len_sq;
			rhs = rhs + term;
			r.hit = (lhs < rhs);
		end else begin
			r.region = sch_pkg::REGION_END;
			r.hit = (e_sq < r_sq);
		end
		return r;
	endfunction

	function automatic query_t make_query(int sx, int sy, int sz, int sr,
			int ax, int ay, int az, int bx, int by, int bz, int cr);
		query_t q;
		q.sphere_x       = CB'(sx);
		q.sphere_y       = CB'(sy);
		q.sphere_z       = CB'(sz);
		q.sphere_radius  = (CB-1)'(sr);
		q.start_x        = CB'(ax);
		q.start_y        = CB'(ay);
		q.start_z        = CB'(az);
		q.end_x          = CB'(bx);
		q.end_y          = CB'(by);
		q.end_z          = CB'(bz);
		q.capsule_radius = (CB-1)'(cr);
		return q;
	endfunction

	function automatic int rand_offset(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	task automatic send_query(query_t q);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query       <= q;
		query_valid <= 1'b1;
		do
			@(posedge clk);
		while (!query_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		query_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2)
			@(posedge clk);
	endtask

	// predictions at query acceptance
	always @(posedge clk) begin
		if (arst_n && query_valid && query_ready) begin
			oldest = predict_hit_region(query);
			expected_hits.insert(expected_hits.size(), oldest);
			query_count++;
			if (oldest.hit)
				hit_count++;
			region_count[oldest.region]++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("result transaction with no query outstanding");
			end else begin
				hit_region_t exp_r;
				exp_r = expected_hits.pop_front();
				if (hit !== exp_r.hit)
					report_mismatch($sformatf("hit %b, expected %b", hit, exp_r.hit));
				if (region !== exp_r.region)
					report_mismatch($sformatf("region %0d, expected %0d",
						region, exp_r.region));
			end
		end
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic test_extremes();
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(-32768, -32768, -32768, 32767,
			32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_query(make_query(32767, 32767, 32767, 32767,
			-32768, -32768, -32768, 32767, 32767, 32767, 32767));
		send_query(make_query(-32768, -32768, -32768, 0,
			-32768, -32768, -32768, 32767, 32767, 32767, 0));
		send_query(make_query(0, 0, 0, 32767,
			-32768, 32767, -32768, 32767, -32768, 32767, 32767));
		send_query(make_query(32767, -32768, 32767, 1,
			-32768, 32767, -32768, -32768, 32767, -32768, 0));
		send_query(make_query(-32768, 32767, 0, 16384,
			32767, -32768, 0, -32768, 32767, 0, 16383));
	endtask

	task automatic test_region_boundaries();
		// projection exactly at start, exactly at end, inside, behind, beyond
		send_query(make_query(0, 40, 0, 20, 0, 0, 0, 100, 0, 0, 30));
		send_query(make_query(100, 40, 0, 20, 0, 0, 0, 100, 0, 0, 30));
		send_query(make_query(50, 40, 0, 20, 0, 0, 0, 100, 0, 0, 30));
		send_query(make_query(-1, 0, 0, 1, 0, 0, 0, 100, 0, 0, 1));
		send_query(make_query(101, 0, 0, 1, 0, 0, 0, 100, 0, 0, 1));
		send_query(make_query(-20000, 5, 5, 100, -100, -100, -100, 100, 100, 100, 100));
	endtask

	task automatic test_touching();
		send_query(make_query(50, 30, 0, 10, 0, 0, 0, 100, 0, 0, 20));
		send_query(make_query(50, 30, 0, 10, 0, 0, 0, 100, 0, 0, 21));
		send_query(make_query(130, 0, 0, 15, 0, 0, 0, 100, 0, 0, 15));
		send_query(make_query(130, 0, 0, 15, 0, 0, 0, 100, 0, 0, 16));
		send_query(make_query(-3, -4, 0, 2, 0, 0, 0, 0, 0, 100, 3));
	endtask

	task automatic test_zero_length_capsule();
		send_query(make_query(5, 5, 8, 1, 5, 5, 5, 5, 5, 5, 3));
		send_query(make_query(5, 5, 9, 1, 5, 5, 5, 5, 5, 5, 3));
		send_query(make_query(-32768, 0, 0, 32767, 32767, 0, 0, 32767, 0, 0, 32767));
	endtask

	task automatic send_random_query();
		int     sp[3], st[3], en[3];
		int     base[3];
		int     span, len, h, p, rsum, sr, cr, ax, pa;
		query_t q;
		case ($urandom_range(5))
			0: begin
				q = QW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
				send_query(q);
			end
			1, 2: begin
				span = 1 << $urandom_range(3, 14);
				for (int k = 0; k < 3; k++) begin
					base[k] = rand_offset(32767);
					sp[k] = clamp_coord(base[k] + rand_offset(span));
					st[k] = clamp_coord(base[k] + rand_offset(span));
					en[k] = clamp_coord(base[k] + rand_offset(span));
				end
				if ($urandom_range(2) == 0)
					en = st;
				send_query(make_query(sp[0], sp[1], sp[2], $urandom_range(span),
					st[0], st[1], st[2], en[0], en[1], en[2], $urandom_range(span)));
			end
			default: begin
				// axis-aligned capsule, sphere placed on, between or beyond region boundaries
				ax = $urandom_range(2);
				pa = (ax + 1 + $urandom_range(1)) % 3;
				for (int k = 0; k < 3; k++)
					base[k] = rand_offset(8000);
				len = $urandom_range(8000);
				h = rand_offset(8000);
				case ($urandom_range(4))
					0: p = 0;
					1: p = len;
					2: p = $urandom_range(len);
					3: p = -int'($urandom_range(1, 50));
					default: p = len + int'($urandom_range(1, 50));
				endcase
				st = base;
				en = base;
				sp = base;
				en[ax] += len;
				sp[ax] += p;
				sp[pa] += h;
				rsum = ((h < 0) ? -h : h) + int'($urandom_range(2)) - 1;
				if (rsum < 0)
					rsum = 0;
				sr = $urandom_range(rsum);
				cr = rsum - sr;
				if ($urandom_range(1))
					send_query(make_query(sp[0], sp[1], sp[2], sr,
						st[0], st[1], st[2], en[0], en[1], en[2], cr));
				else
					send_query(make_query(sp[0], sp[1], sp[2], sr,
						en[0], en[1], en[2], st[0], st[1], st[2], cr));
			end
		endcase
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_pct, int n);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_random_query();
		wait_drained();
	endtask

	initial begin
		arst_n             = 1'b0;
		query_valid        = 1'b0;
		query              = '0;
		result_ready       = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		error_count        = 0;
		query_count        = 0;
		hit_count          = 0;
		region_count       = '{0, 0, 0};
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_region_boundaries();
		wait_drained();
		sender_idle_pct = 67;
		receiver_stall_pct = 67;
		test_touching();
		test_zero_length_capsule();
		wait_drained();

		test_random_traffic(0, 0, RAND_PER_MIX);
		test_random_traffic(67, 0, RAND_PER_MIX);
		test_random_traffic(0, 67, RAND_PER_MIX);
		test_random_traffic(28, 28, RAND_PER_MIX);

		$display("covered %0d queries, %0d hits; interior %0d, end %0d, start %0d",
			query_count, hit_count, region_count[sch_pkg::REGION_INTERIOR],
			region_count[sch_pkg::REGION_END], region_count[sch_pkg::REGION_START]);
		$display("traffic mixes: back to back, sender gaps, receiver stalls, both");
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("mismatches: %0d", error_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/sch_pkg.sv
design/sphere_capsule_hit_test.sv
bench/sphere_capsule_hit_test_test.sv
